### rtl/sfsd_pkg.sv
// Shared codes, default sizes and the flow table's command and lookup types.
package sfsd_pkg;

  // Default table depths
  localparam int unsigned STREAM_ENTRIES_DEF = 8;
  localparam int unsigned FLOW_ENTRIES_DEF   = 16;

  // Event kinds carried in the func field
  localparam logic [2:0] FUNC_DATA      = 3'd0;
  localparam logic [2:0] FUNC_SETUP     = 3'd1;
  localparam logic [2:0] FUNC_ADD_SUB   = 3'd2;
  localparam logic [2:0] FUNC_REM_SUB   = 3'd3;
  localparam logic [2:0] FUNC_ADD_IMAGE = 3'd4;
  localparam logic [2:0] FUNC_REM_IMAGE = 3'd5;
  localparam logic [2:0] FUNC_CLR_COOL  = 3'd6;
  localparam logic [2:0] FUNC_CLR_PEND  = 3'd7;

  // Result actions
  localparam logic [2:0] ACT_NONE        = 3'd0;
  localparam logic [2:0] ACT_FORWARD     = 3'd1;
  localparam logic [2:0] ACT_ELICIT      = 3'd2;
  localparam logic [2:0] ACT_CREATE      = 3'd3;
  localparam logic [2:0] ACT_DEACT_STRM  = 3'd4;
  localparam logic [2:0] ACT_IMG_ACTIVE  = 3'd5;
  localparam logic [2:0] ACT_DEACT_IMAGE = 3'd6;

  // Error codes
  localparam logic [1:0] ERR_NONE    = 2'd0;
  localparam logic [1:0] ERR_UNKNOWN = 2'd1;
  localparam logic [1:0] ERR_FULL    = 2'd2;

  // Flow states
  localparam logic [1:0] ST_PENDING = 2'd0;
  localparam logic [1:0] ST_INIT    = 2'd1;
  localparam logic [1:0] ST_COOL    = 2'd2;
  localparam logic [1:0] ST_ACTIVE  = 2'd3;

  // Flow table operations
  localparam logic [1:0] FOP_NONE = 2'd0;
  localparam logic [1:0] FOP_SET  = 2'd1;
  localparam logic [1:0] FOP_FREE = 2'd2;

  typedef struct packed {
    logic [1:0] op;     // FOP_* code
    logic [1:0] state;  // state to write on FOP_SET
  } flow_cmd_t;

  typedef struct packed {
    logic       hit;    // key present in the table
    logic       full;   // no free slot left
    logic [1:0] state;  // state of the matching flow, zero on a miss
  } flow_look_t;

endpackage

### rtl/sfsd_flow_table.sv
// Flow table: parallel key match, lowest-free allocation, state update and release.
module sfsd_flow_table #(
  parameter int unsigned FLOW_ENTRIES = sfsd_pkg::FLOW_ENTRIES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [31:0]         key_stream,
  input  logic [31:0]         key_session,
  input  sfsd_pkg::flow_cmd_t cmd,
  output sfsd_pkg::flow_look_t look
);
  import sfsd_pkg::*;

  logic [FLOW_ENTRIES-1:0] valid_r;
  logic [FLOW_ENTRIES-1:0] valid_nxt;
  logic [FLOW_ENTRIES-1:0] match;
  logic [FLOW_ENTRIES-1:0] free_vec;
  logic [FLOW_ENTRIES-1:0] free_oh;
  logic [FLOW_ENTRIES-1:0] wr_vec;
  logic [31:0]             stream_r  [FLOW_ENTRIES];
  logic [31:0]             session_r [FLOW_ENTRIES];
  logic [1:0]              state_r   [FLOW_ENTRIES];
  logic [1:0]              state_or;

  always_comb begin
    for (int i = 0; i < FLOW_ENTRIES; i++) begin
      match[i] = valid_r[i] && (stream_r[i] == key_stream) && (session_r[i] == key_session);
    end
  end

  // Lowest free slot as a one-hot vector
  assign free_vec = ~valid_r;
  assign free_oh  = free_vec & (~free_vec + FLOW_ENTRIES'(1));

  // Keys are unique, so at most one entry matches
  always_comb begin
    state_or = '0;
    for (int i = 0; i < FLOW_ENTRIES; i++) begin
      state_or = state_or | (match[i] ? state_r[i] : 2'b00);
    end
  end

  assign look.hit   = |match;
  assign look.full  = &valid_r;
  assign look.state = state_or;

  assign wr_vec = (cmd.op == FOP_SET) ? (look.hit ? match : free_oh) : '0;

  always_comb begin
    for (int i = 0; i < FLOW_ENTRIES; i++) begin
      valid_nxt[i] = valid_r[i];
      if (wr_vec[i]) begin
        valid_nxt[i] = 1'b1;
      end else if ((cmd.op == FOP_FREE) && match[i]) begin
        valid_nxt[i] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < FLOW_ENTRIES; i++) begin
      if (wr_vec[i]) begin
        stream_r[i]  <= key_stream;
        session_r[i] <= key_session;
        state_r[i]   <= cmd.state;
      end
    end
  end

endmodule

### rtl/session_flow_state_dispatcher_top.sv
// Session flow state dispatcher: classify one receive event per cycle against stream and flow tables.
//
// An event taken on start passes through the input register and the result register to out_valid.
// Throughput: one event per cycle; busy never rises. The tables are read and updated in
// the single decision stage, so each event sees every update of the one before it.
// Reset (synchronous, rst_n low) empties both tables by clearing their valid bits and
// drops any event in flight; no clearing pass is needed. The receiver cannot stall.
module session_flow_state_dispatcher_top #(
  parameter int unsigned STREAM_ENTRIES = sfsd_pkg::STREAM_ENTRIES_DEF,
  parameter int unsigned FLOW_ENTRIES   = sfsd_pkg::FLOW_ENTRIES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  // Event beat
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         in_func,
  input  logic signed [31:0] in_stream_id,
  input  logic signed [31:0] in_session_id,
  input  logic               in_is_multicast,
  input  logic signed [31:0] in_term_id,
  input  logic [30:0]        in_term_offset,
  input  logic signed [31:0] in_initial_term_id,
  input  logic [30:0]        in_term_length,
  input  logic [15:0]        in_mtu,
  // Result beat
  output logic               out_valid,
  output logic [2:0]         out_action,
  output logic [1:0]         out_error_code,
  output logic signed [31:0] out_stream_id,
  output logic signed [31:0] out_session_id,
  output logic               out_use_remote_control,
  output logic signed [31:0] out_term_id,
  output logic [30:0]        out_term_offset,
  output logic signed [31:0] out_initial_term_id,
  output logic [30:0]        out_term_length,
  output logic [15:0]        out_mtu
);
  import sfsd_pkg::*;

  // ---------------------------------------------------------------------------
  // Input register: capture every beat, nothing ever holds the sender off
  // ---------------------------------------------------------------------------
  logic               accept;
  logic               in_vld_r;
  logic [2:0]         func_r;
  logic [31:0]        stream_id_r;
  logic [31:0]        session_id_r;
  logic               mcast_r;
  logic [31:0]        term_id_r;
  logic [30:0]        term_offset_r;
  logic [31:0]        init_term_id_r;
  logic [30:0]        term_length_r;
  logic [15:0]        mtu_r;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      func_r         <= in_func;
      stream_id_r    <= in_stream_id;
      session_id_r   <= in_session_id;
      mcast_r        <= in_is_multicast;
      term_id_r      <= in_term_id;
      term_offset_r  <= in_term_offset;
      init_term_id_r <= in_initial_term_id;
      term_length_r  <= in_term_length;
      mtu_r          <= in_mtu;
    end
  end

  // ---------------------------------------------------------------------------
  // Subscription table: valid bits reset, keys only read under their valid bit
  // ---------------------------------------------------------------------------
  logic [STREAM_ENTRIES-1:0] strm_valid_r;
  logic [STREAM_ENTRIES-1:0] strm_valid_nxt;
  logic [31:0]               strm_key_r [STREAM_ENTRIES];
  logic [STREAM_ENTRIES-1:0] strm_match;
  logic [STREAM_ENTRIES-1:0] strm_free;
  logic [STREAM_ENTRIES-1:0] strm_free_oh;
  logic [STREAM_ENTRIES-1:0] strm_wr;
  logic                      strm_hit;
  logic                      strm_full;
  logic                      strm_add;

  always_comb begin
    for (int i = 0; i < STREAM_ENTRIES; i++) begin
      strm_match[i] = strm_valid_r[i] && (strm_key_r[i] == stream_id_r);
    end
  end

  assign strm_hit     = |strm_match;
  assign strm_full    = &strm_valid_r;
  assign strm_free    = ~strm_valid_r;
  assign strm_free_oh = strm_free & (~strm_free + STREAM_ENTRIES'(1));
  assign strm_wr      = strm_add ? strm_free_oh : '0;
  assign strm_valid_nxt = strm_valid_r | strm_wr;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strm_valid_r <= '0;
    end else begin
      strm_valid_r <= strm_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < STREAM_ENTRIES; i++) begin
      if (strm_wr[i]) begin
        strm_key_r[i] <= stream_id_r;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Flow table, keyed by stream and session
  // ---------------------------------------------------------------------------
  flow_cmd_t  fcmd;
  flow_look_t flook;
  logic       flow_room;

  sfsd_flow_table #(
    .FLOW_ENTRIES (FLOW_ENTRIES)
  ) u_flow_table (
    .clk         (clk),
    .rst_n       (rst_n),
    .key_stream  (stream_id_r),
    .key_session (session_id_r),
    .cmd         (fcmd),
    .look        (flook)
  );

  // A flow can take a state when it is already known or a slot is free
  assign flow_room = flook.hit || !flook.full;

  // ---------------------------------------------------------------------------
  // Decision: one pass over the registered event and both lookups
  // ---------------------------------------------------------------------------
  logic        out_valid_r,      out_valid_nxt;
  logic [2:0]  out_action_r,     out_action_nxt;
  logic [1:0]  out_err_r,        out_err_nxt;
  logic [31:0] out_stream_r,     out_stream_nxt;
  logic [31:0] out_session_r,    out_session_nxt;
  logic        out_urc_r,        out_urc_nxt;
  logic [31:0] out_term_id_r,    out_term_id_nxt;
  logic [30:0] out_term_off_r,   out_term_off_nxt;
  logic [31:0] out_init_term_r,  out_init_term_nxt;
  logic [30:0] out_term_len_r,   out_term_len_nxt;
  logic [15:0] out_mtu_r,        out_mtu_nxt;

  always_comb begin
    fcmd.op           = FOP_NONE;
    fcmd.state        = ST_PENDING;
    strm_add          = 1'b0;
    out_valid_nxt     = in_vld_r;
    out_action_nxt    = ACT_NONE;
    out_err_nxt       = ERR_NONE;
    out_stream_nxt    = stream_id_r;
    out_session_nxt   = session_id_r;
    out_urc_nxt       = 1'b0;
    out_term_id_nxt   = '0;
    out_term_off_nxt  = '0;
    out_init_term_nxt = '0;
    out_term_len_nxt  = '0;
    out_mtu_nxt       = '0;

    unique case (func_r)
      FUNC_DATA: begin
        if (strm_hit) begin
          if (flook.hit) begin
            // Forward only on an active flow, drop in any other state
            if (flook.state == ST_ACTIVE) begin
              out_action_nxt   = ACT_FORWARD;
              out_term_id_nxt  = term_id_r;
              out_term_off_nxt = term_offset_r;
            end
          end else if (flook.full) begin
            out_err_nxt = ERR_FULL;
          end else begin
            // Unknown flow: record it as pending and ask for a setup
            fcmd.op        = FOP_SET;
            fcmd.state     = ST_PENDING;
            out_action_nxt = ACT_ELICIT;
            out_urc_nxt    = mcast_r;
          end
        end
      end
      FUNC_SETUP: begin
        if (strm_hit && (!flook.hit || (flook.state == ST_PENDING))) begin
          if (!flow_room) begin
            out_err_nxt = ERR_FULL;
          end else begin
            fcmd.op           = FOP_SET;
            fcmd.state        = ST_INIT;
            out_action_nxt    = ACT_CREATE;
            out_urc_nxt       = mcast_r;
            out_term_id_nxt   = term_id_r;
            out_term_off_nxt  = term_offset_r;
            out_init_term_nxt = init_term_id_r;
            out_term_len_nxt  = term_length_r;
            out_mtu_nxt       = mtu_r;
          end
        end
      end
      FUNC_ADD_SUB: begin
        if (!strm_hit) begin
          if (strm_full) begin
            out_err_nxt = ERR_FULL;
          end else begin
            strm_add = 1'b1;
          end
        end
      end
      FUNC_REM_SUB: begin
        // The stream entry and its flows stay in place
        if (strm_hit) begin
          out_action_nxt = ACT_DEACT_STRM;
        end else begin
          out_err_nxt = ERR_UNKNOWN;
        end
      end
      FUNC_ADD_IMAGE: begin
        if (!strm_hit) begin
          out_err_nxt = ERR_UNKNOWN;
        end else if (!flow_room) begin
          out_err_nxt = ERR_FULL;
        end else begin
          fcmd.op        = FOP_SET;
          fcmd.state     = ST_ACTIVE;
          out_action_nxt = ACT_IMG_ACTIVE;
        end
      end
      FUNC_REM_IMAGE: begin
        // Always report the deactivation; record cool-down even on an unknown stream
        out_action_nxt = ACT_DEACT_IMAGE;
        if (!flow_room) begin
          out_err_nxt = ERR_FULL;
        end else begin
          fcmd.op    = FOP_SET;
          fcmd.state = ST_COOL;
        end
      end
      FUNC_CLR_COOL: begin
        if (flook.hit && (flook.state == ST_COOL)) begin
          fcmd.op = FOP_FREE;
        end
      end
      FUNC_CLR_PEND: begin
        if (flook.hit && (flook.state == ST_PENDING)) begin
          fcmd.op = FOP_FREE;
        end
      end
      default: begin
        fcmd.op = FOP_NONE;
      end
    endcase

    // Drop table updates when no event sits in the input register
    if (!in_vld_r) begin
      fcmd.op  = FOP_NONE;
      strm_add = 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Result register: the strobe lasts one cycle per beat
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_vld_r) begin
      out_action_r    <= out_action_nxt;
      out_err_r       <= out_err_nxt;
      out_stream_r    <= out_stream_nxt;
      out_session_r   <= out_session_nxt;
      out_urc_r       <= out_urc_nxt;
      out_term_id_r   <= out_term_id_nxt;
      out_term_off_r  <= out_term_off_nxt;
      out_init_term_r <= out_init_term_nxt;
      out_term_len_r  <= out_term_len_nxt;
      out_mtu_r       <= out_mtu_nxt;
    end
  end

  assign out_valid              = out_valid_r;
  assign out_action             = out_action_r;
  assign out_error_code         = out_err_r;
  assign out_stream_id          = out_stream_r;
  assign out_session_id         = out_session_r;
  assign out_use_remote_control = out_urc_r;
  assign out_term_id            = out_term_id_r;
  assign out_term_offset        = out_term_off_r;
  assign out_initial_term_id    = out_init_term_r;
  assign out_term_length        = out_term_len_r;
  assign out_mtu                = out_mtu_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // Every registered event yields exactly one result beat on the next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_vld_r |=> out_valid)
    else $error("registered event produced no result beat");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    !in_vld_r |=> !out_valid)
    else $error("result beat without a registered event");

  // A subscribed stream id is held once only
  a_stream_unique: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(strm_match))
    else $error("stream id present in more than one entry");

  // An unknown-subscription error never comes with an action
  a_unknown_no_action: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_error_code == ERR_UNKNOWN)) |-> (out_action == ACT_NONE))
    else $error("unknown subscription reported together with an action");

endmodule
